>>> hdl/instrument_name_matcher_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the instrument name matcher.
// All checks run on the rising edge of clock and are disabled during reset.
// ---------------------------------------------------------------------------
`ifndef INSTRUMENT_NAME_MATCHER_ASSERT_SVH
`define INSTRUMENT_NAME_MATCHER_ASSERT_SVH

// Same-cycle implication.
`define INM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define INM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/inm_pkg.sv
// ---------------------------------------------------------------------------
// inm_pkg
// Types, codes and character helpers shared by the instrument name matcher.
// ---------------------------------------------------------------------------
package inm_pkg;

   typedef enum logic [3:0] {
      PH_START  = 4'd0,
      PH_ROOT   = 4'd1,
      PH_DASH1  = 4'd2,
      PH_PERP   = 4'd3,
      PH_DAY    = 4'd4,
      PH_MON    = 4'd5,
      PH_YEAR   = 4'd6,
      PH_DASH2  = 4'd7,
      PH_STRIKE = 4'd8,
      PH_DEC0   = 4'd9,
      PH_DEC    = 4'd10,
      PH_DASH3  = 4'd11,
      PH_CP     = 4'd12,
      PH_DEAD   = 4'd13
   } phase_type;

   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_PERP   = 2'd1,
      KIND_FUTURE = 2'd2,
      KIND_OPTION = 2'd3
   } kind_type;

   localparam logic [3:0] PERP_LEN = 4'd9;

   typedef struct packed {
      logic [7:0] ch;
      logic       char_present;
      logic       last;
   } req_type;

   typedef struct packed {
      logic       valid_res;
      logic [1:0] kind;
   } rsp_type;

   typedef struct packed {
      phase_type  phase;
      logic [3:0] run_count;
   } match_state_type;

   function automatic logic is_upper(input logic [7:0] c);
      return (c >= 8'h41) && (c <= 8'h5a);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   // Letters of PERPETUAL; index 0 is the P taken in the dash state.
   function automatic logic [7:0] perp_char(input logic [3:0] idx);
      logic [7:0] c;
      case (idx)
         4'd0: c = 8'h50;
         4'd1: c = 8'h45;
         4'd2: c = 8'h52;
         4'd3: c = 8'h50;
         4'd4: c = 8'h45;
         4'd5: c = 8'h54;
         4'd6: c = 8'h55;
         4'd7: c = 8'h41;
         4'd8: c = 8'h4c;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

>>> hdl/inm_step.sv
// ---------------------------------------------------------------------------
// inm_step
// One matcher transition on a character, plus the verdict on the new state.
// ---------------------------------------------------------------------------
module inm_step (
   input  inm_pkg::match_state_type cur_state,
   input  inm_pkg::req_type         item,
   output inm_pkg::match_state_type next_state,
   output inm_pkg::kind_type        kind
);
   import inm_pkg::*;

   logic [7:0]      c;
   logic [3:0]      n;
   logic            up;
   logic            dig;
   logic [3:0]      n_inc;
   match_state_type adv;

   assign c     = item.ch;
   assign n     = cur_state.run_count;
   assign up    = is_upper(c);
   assign dig   = is_digit(c);
   assign n_inc = n + 4'd1;

   always_comb begin
      adv.phase     = PH_DEAD;
      adv.run_count = 4'd0;
      case (cur_state.phase)
         PH_START: begin
            if (up) adv.phase = PH_ROOT;
         end
         PH_ROOT: begin
            if (up) adv.phase = PH_ROOT;
            else if (c == 8'h2d) adv.phase = PH_DASH1;
         end
         PH_DASH1: begin
            if (c == 8'h50) begin
               adv.phase     = PH_PERP;
               adv.run_count = 4'd1;
            end else if (dig) begin
               adv.phase     = PH_DAY;
               adv.run_count = 4'd1;
            end
         end
         PH_PERP: begin
            if ((n < PERP_LEN) && (c == perp_char(n))) begin
               adv.phase     = PH_PERP;
               adv.run_count = n_inc;
            end
         end
         PH_DAY: begin
            if (dig && (n < 4'd2)) begin
               adv.phase     = PH_DAY;
               adv.run_count = n_inc;
            end else if (up) begin
               adv.phase     = PH_MON;
               adv.run_count = 4'd1;
            end
         end
         PH_MON: begin
            if (up && (n < 4'd3)) begin
               adv.phase     = PH_MON;
               adv.run_count = n_inc;
            end else if (dig && (n == 4'd3)) begin
               adv.phase     = PH_YEAR;
               adv.run_count = 4'd1;
            end
         end
         PH_YEAR: begin
            if (dig && (n < 4'd4)) begin
               adv.phase     = PH_YEAR;
               adv.run_count = n_inc;
            end else if ((c == 8'h2d) && (n >= 4'd2)) begin
               adv.phase = PH_DASH2;
            end
         end
         PH_DASH2: begin
            if (dig) adv.phase = PH_STRIKE;
         end
         PH_STRIKE: begin
            if (dig) adv.phase = PH_STRIKE;
            else if (c == 8'h64) adv.phase = PH_DEC0;
            else if (c == 8'h2d) adv.phase = PH_DASH3;
         end
         PH_DEC0: begin
            if (dig) adv.phase = PH_DEC;
         end
         PH_DEC: begin
            if (dig) adv.phase = PH_DEC;
            else if (c == 8'h2d) adv.phase = PH_DASH3;
         end
         PH_DASH3: begin
            if ((c == 8'h43) || (c == 8'h50)) adv.phase = PH_CP;
         end
         default: begin
            adv.phase = PH_DEAD;
         end
      endcase
   end

   // An item without a character leaves the state alone.
   assign next_state = item.char_present ? adv : cur_state;

   always_comb begin
      kind = KIND_NONE;
      if ((next_state.phase == PH_PERP) && (next_state.run_count == PERP_LEN))
         kind = KIND_PERP;
      else if ((next_state.phase == PH_YEAR) && (next_state.run_count >= 4'd2)
               && (next_state.run_count <= 4'd4))
         kind = KIND_FUTURE;
      else if (next_state.phase == PH_CP)
         kind = KIND_OPTION;
   end

endmodule

>>> hdl/instrument_name_matcher.sv
// ---------------------------------------------------------------------------
// instrument_name_matcher
// Streams an instrument name one character per request and reports on the
// last character whether it is a perpetual, future or option name.
// ---------------------------------------------------------------------------
//  channel  | ports                          | moves
//  ---------+--------------------------------+-------------------------------
//  request  | req_valid req_ready req_payload| one name character (+ last)
//  response | rsp_valid rsp_ready rsp_payload| verdict, only after a last item
//
//  One request per cycle sustained while no last request waits on a stalled
//  response: input register, one transition of the matcher, result register.
//  The matcher state updates as a request leaves the input register.
//  A stalled response holds back only a last request; others keep flowing.
//  Synchronous reset returns the matcher to the start of a name.
// ---------------------------------------------------------------------------
`include "instrument_name_matcher_assert.svh"

module instrument_name_matcher (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  inm_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output inm_pkg::rsp_type rsp_payload
);
   import inm_pkg::*;

   logic            s1_valid_ff, s1_valid_in;
   req_type         s1_item_ff, s1_item_in;
   match_state_type state_ff, state_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_payload_ff, rsp_payload_in;

   match_state_type step_state;
   kind_type        step_kind;
   logic            out_free;
   logic            s1_fire;
   logic            req_fire;

   inm_step u_step (
      .cur_state  (state_ff),
      .item       (s1_item_ff),
      .next_state (step_state),
      .kind       (step_kind)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_fire   = s1_valid_ff && (!s1_item_ff.last || out_free);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      s1_valid_in    = s1_valid_ff;
      s1_item_in     = s1_item_ff;
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;

      if (req_fire) begin
         s1_valid_in = 1'b1;
         s1_item_in  = req_payload;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      if (s1_fire) begin
         if (s1_item_ff.last) begin
            state_in.phase           = PH_START;
            state_in.run_count       = 4'd0;
            rsp_valid_in             = 1'b1;
            rsp_payload_in.valid_res = (step_kind != KIND_NONE);
            rsp_payload_in.kind      = step_kind;
         end else begin
            state_in = step_state;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         state_ff.phase     <= PH_START;
         state_ff.run_count <= 4'd0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
      s1_item_ff     <= s1_item_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `INM_ASSERT_NEXT(a_restart_after_last, s1_fire && s1_item_ff.last, (state_ff.phase == PH_START) && (state_ff.run_count == 4'd0), "matcher did not restart after last request")
   `INM_ASSERT_NOW(a_verdict_consistent, rsp_valid_ff, rsp_payload_ff.valid_res == (rsp_payload_ff.kind != KIND_NONE), "verdict flag and kind disagree")
   `INM_ASSERT_NOW(a_stall_only_on_last, !req_ready, s1_valid_ff && s1_item_ff.last && !out_free, "request side stalled without a blocked last request")
   `INM_ASSERT_NOW(a_perp_count_bound, state_ff.phase == PH_PERP, (state_ff.run_count >= 4'd1) && (state_ff.run_count <= PERP_LEN), "perpetual run count out of range")

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: testbench for instrument_name_matcher
// Streams instrument names through the request channel and checks every
// verdict against a cycle-free model of the name matcher. Names are mostly
// well-formed perpetual, future and option names with random content, mixed
// with mangled names, noise and empty names, under several idle patterns.
// ---------------------------------------------------------------------------
module tb_top;
   import inm_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam logic [71:0] PERP_TEXT = "PERPETUAL";

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   // idle knobs, percent of cycles
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   int items_sent = 0;
   int fail_count = 0;
   int cycle_count = 0;

   // model state
   phase_type  match_phase = PH_START;
   logic [3:0] match_count = '0;

   rsp_type expected_verdicts[$];
   rsp_type model_verdict;
   rsp_type want;
   logic [7:0] name_chars[$];

   instrument_name_matcher u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Matcher model: advances on one request, returns the verdict when last.
   // ------------------------------------------------------------------------
   function automatic rsp_type match_step(input req_type r);
      phase_type  np;
      logic [3:0] nn;
      logic       upper;
      logic       digit;
      kind_type   k;
      rsp_type    res;
      upper = (r.ch >= "A") && (r.ch <= "Z");
      digit = (r.ch >= "0") && (r.ch <= "9");
      res = '0;
      if (r.char_present) begin
         np = PH_DEAD;
         nn = '0;
         case (match_phase)
            PH_START: if (upper) np = PH_ROOT;
            PH_ROOT: begin
               if (upper) np = PH_ROOT;
               else if (r.ch == "-") np = PH_DASH1;
            end
            PH_DASH1: begin
               if (r.ch == "P") begin
                  np = PH_PERP;
                  nn = 4'd1;
               end else if (digit) begin
                  np = PH_DAY;
                  nn = 4'd1;
               end
            end
            PH_PERP: begin
               if (match_count < PERP_LEN) begin
                  if (r.ch == PERP_TEXT[(8 - match_count) * 8 +: 8]) begin
                     np = PH_PERP;
                     nn = match_count + 4'd1;
                  end
               end
            end
            PH_DAY: begin
               if (digit && match_count < 4'd2) begin
                  np = PH_DAY;
                  nn = match_count + 4'd1;
               end else if (upper) begin
                  np = PH_MON;
                  nn = 4'd1;
               end
            end
            PH_MON: begin
               if (upper && match_count < 4'd3) begin
                  np = PH_MON;
                  nn = match_count + 4'd1;
               end else if (digit && match_count == 4'd3) begin
                  np = PH_YEAR;
                  nn = 4'd1;
               end
            end
            PH_YEAR: begin
               if (digit && match_count < 4'd4) begin
                  np = PH_YEAR;
                  nn = match_count + 4'd1;
               end else if (r.ch == "-" && match_count >= 4'd2) begin
                  np = PH_DASH2;
               end
            end
            PH_DASH2: if (digit) np = PH_STRIKE;
            PH_STRIKE: begin
               if (digit) np = PH_STRIKE;
               else if (r.ch == "d") np = PH_DEC0;
               else if (r.ch == "-") np = PH_DASH3;
            end
            PH_DEC0: if (digit) np = PH_DEC;
            PH_DEC: begin
               if (digit) np = PH_DEC;
               else if (r.ch == "-") np = PH_DASH3;
            end
            PH_DASH3: if (r.ch == "C" || r.ch == "P") np = PH_CP;
            default: ;
         endcase
         match_phase = np;
         match_count = nn;
      end
      if (r.last) begin
         k = KIND_NONE;
         if (match_phase == PH_PERP && match_count == PERP_LEN) k = KIND_PERP;
         else if (match_phase == PH_YEAR && match_count >= 4'd2 && match_count <= 4'd4)
            k = KIND_FUTURE;
         else if (match_phase == PH_CP) k = KIND_OPTION;
         res.valid_res = (k != KIND_NONE);
         res.kind = k;
         match_phase = PH_START;
         match_count = '0;
      end
      return res;
   endfunction

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
   endtask

   // Requests feed the model; responses are checked against the oldest verdict.
   always @(posedge clock) begin
      if (reset) begin
         match_phase = PH_START;
         match_count = '0;
      end else begin
         if (req_valid && req_ready) begin
            model_verdict = match_step(req_payload);
            if (req_payload.last) expected_verdicts.push_back(model_verdict);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               note_failure($sformatf("unexpected response valid_res=%0b kind=%0d",
                                      rsp_payload.valid_res, rsp_payload.kind));
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_payload.valid_res !== want.valid_res)
                  note_failure($sformatf("valid_res mismatch: expected %0b, got %0b",
                                         want.valid_res, rsp_payload.valid_res));
               if (rsp_payload.kind !== want.kind)
                  note_failure($sformatf("kind mismatch: expected %0d, got %0d",
                                         want.kind, rsp_payload.kind));
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL instrument_name_matcher");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Request driver
   // ------------------------------------------------------------------------
   task automatic send_request(input logic [7:0] c, input logic present,
                               input logic is_last);
      req_type r;
      r.ch = c;
      r.char_present = present;
      r.last = is_last;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      if (present || is_last) items_sent++;
   endtask

   // Sends name_chars, now and then slipping in requests that carry no character.
   task automatic send_name();
      logic tail_gap;
      tail_gap = (name_chars.size() == 0) || ($urandom_range(0, 19) == 0);
      foreach (name_chars[i]) begin
         if ($urandom_range(0, 19) == 0) send_request(8'($urandom()), 1'b0, 1'b0);
         send_request(name_chars[i], 1'b1, !tail_gap && (i == name_chars.size() - 1));
      end
      if (tail_gap) send_request(8'($urandom()), 1'b0, 1'b1);
   endtask

   function automatic logic [7:0] rand_upper();
      return 8'($urandom_range("A", "Z"));
   endfunction

   function automatic logic [7:0] rand_digit();
      return 8'($urandom_range("0", "9"));
   endfunction

   function automatic logic [7:0] stray_char();
      case ($urandom_range(0, 6))
         0: return rand_digit();
         1: return rand_upper();
         2: return "-";
         3: return "d";
         4: return $urandom_range(0, 1) ? "C" : "P";
         5: return 8'($urandom_range("a", "z"));
         default: return 8'($urandom());
      endcase
   endfunction

   function automatic void build_name(input kind_type k);
      name_chars.delete();
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4))
         name_chars.push_back(rand_upper());
      name_chars.push_back("-");
      if (k == KIND_PERP) begin
         for (int i = 0; i < 9; i++) name_chars.push_back(PERP_TEXT[(8 - i) * 8 +: 8]);
      end else begin
         repeat ($urandom_range(1, 2)) name_chars.push_back(rand_digit());
         repeat (3) name_chars.push_back(rand_upper());
         repeat ($urandom_range(2, 4)) name_chars.push_back(rand_digit());
         if (k == KIND_OPTION) begin
            name_chars.push_back("-");
            repeat ($urandom_range(1, 4)) name_chars.push_back(rand_digit());
            if ($urandom_range(0, 1)) begin
               name_chars.push_back("d");
               repeat ($urandom_range(1, 3)) name_chars.push_back(rand_digit());
            end
            name_chars.push_back("-");
            name_chars.push_back($urandom_range(0, 1) ? "C" : "P");
         end
      end
   endfunction

   // Truncate the tail, or overwrite, insert or append one character.
   function automatic void mangle_name();
      int pos;
      pos = $urandom_range(1, name_chars.size() - 1);
      case ($urandom_range(0, 3))
         0: repeat (name_chars.size() - pos) void'(name_chars.pop_back());
         1: name_chars[pos] = stray_char();
         2: name_chars.insert(pos, stray_char());
         default: name_chars.push_back(stray_char());
      endcase
   endfunction

   function automatic void load_text(input string s);
      name_chars.delete();
      for (int i = 0; i < s.len(); i++) name_chars.push_back(s[i]);
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_empty_and_dead();
      send_request(8'h00, 1'b0, 1'b1);
      send_request(8'hff, 1'b1, 1'b1);
   endtask

   task automatic test_perpetual_name();
      send_request("Z", 1'b1, 1'b0);
      send_request("-", 1'b1, 1'b0);
      send_request(8'hff, 1'b0, 1'b0);
      load_text("PERPETUAL");
      foreach (name_chars[i])
         send_request(name_chars[i], 1'b1, i == name_chars.size() - 1);
   endtask

   task automatic test_option_name();
      load_text("A-0ABC99-0-C");
      foreach (name_chars[i])
         send_request(name_chars[i], 1'b1, i == name_chars.size() - 1);
   endtask

   task automatic test_random_names(input int idle_pct, input int stall_pct,
                                    input int count);
      int first;
      int pick;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      first = items_sent;
      while (items_sent - first < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            name_chars.delete();
         end else if (pick < 20) begin
            build_name(KIND_PERP);
         end else if (pick < 45) begin
            build_name(KIND_FUTURE);
         end else if (pick < 75) begin
            build_name(KIND_OPTION);
         end else if (pick < 90) begin
            build_name(kind_type'($urandom_range(1, 3)));
            mangle_name();
         end else begin
            name_chars.delete();
            repeat ($urandom_range(1, 8))
               name_chars.push_back($urandom_range(0, 1) ? stray_char() : 8'($urandom()));
         end
         send_name();
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_empty_and_dead();
      test_perpetual_name();
      test_option_name();
      test_random_names(0, 0, 275);
      test_random_names(61, 0, 275);
      test_random_names(0, 61, 275);
      test_random_names(17, 17, 275);
      req_valid <= 1'b0;

      // let the checker log the final request before looking at the queue
      @(posedge clock);
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS instrument_name_matcher");
      end else begin
         $display("FAIL instrument_name_matcher");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+hdl
hdl/inm_pkg.sv
hdl/inm_step.sv
hdl/instrument_name_matcher.sv
tb/sv/tb_top.sv
